@@ hdl/irpd_pkg.sv @@
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types, constants and key patterns of the IR pulse-distance decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

  // buffer sizing
  localparam int BUFFER_BYTES = 16;
  localparam int MATCH_BYTES  = 9;
  localparam int POWER_BYTES  = 3;
  localparam int BYTE_POS_W   = $clog2(BUFFER_BYTES + 1);
  localparam int MATCH_IDX_W  = $clog2(MATCH_BYTES);
  localparam int CODE_W       = MATCH_BYTES * 8;
  localparam int CODE_IDX_W   = $clog2(CODE_W);

  // field widths
  localparam int TICK_W    = 32;
  localparam int THR_W     = 8;
  localparam int WINDOW_W  = 16;
  localparam int ACTION_W  = 2;
  localparam int STEP_W    = 5;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 8;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [THR_W-1:0]    THR_RESET    = 8'h15;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd10000;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  // key patterns, first byte in the lowest bits
  localparam logic [POWER_BYTES*8-1:0] PAT_POWER_ON  = 24'h02_08_8B;
  localparam logic [POWER_BYTES*8-1:0] PAT_POWER_OFF = 24'h02_08_83;
  localparam logic [CODE_W-1:0] PAT_VOL_UP   = 72'h04_51_51_04_00_01_50_01_57;
  localparam logic [CODE_W-1:0] PAT_VOL_DOWN = 72'h04_54_41_01_10_01_50_01_57;

  // volume steps
  localparam logic [STEP_W-1:0] STEP_SINGLE = 5'd1;
  localparam logic [STEP_W-1:0] STEP_REPEAT = 5'd8;

  typedef enum logic [0:0] {
    CMD_EDGE    = 1'b0,
    CMD_TIMEOUT = 1'b1
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BIT_THRESHOLD = 2'd0,
    CFG_REPEAT_WINDOW = 2'd1,
    CFG_LEARN_MODE    = 2'd2
  } cfg_idx_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE      = 2'd0,
    ACT_POWER_ON  = 2'd1,
    ACT_POWER_OFF = 2'd2,
    ACT_VOLUME    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    MATCH_NONE,
    MATCH_POWER_ON,
    MATCH_POWER_OFF,
    MATCH_VOL_UP,
    MATCH_VOL_DOWN
  } match_t;

  typedef struct packed {
    logic [THR_W-1:0]    bit_threshold;
    logic [WINDOW_W-1:0] repeat_window;
    logic                learn_mode;
  } cfg_t;

  typedef struct packed {
    match_t            kind;
    logic [TICK_W-1:0] tick;
  } qentry_t;

  typedef struct packed {
    logic [BYTE_POS_W-1:0] byte_pos;
    logic [2:0]            bit_pos;
  } front_status_t;

endpackage

@@ hdl/irpd_front.sv @@
// ----------------------------------------------------------------------------
// irpd_front
// Accepts edge and timeout words, collects code bits and classifies bursts.
// ----------------------------------------------------------------------------
module irpd_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [irpd_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // level, tick, zero pad
  input  logic                            s_axis_tuser,  // cmd
  input  irpd_pkg::cfg_t                  cfg,
  input  logic                            q_full,
  output logic                            q_push,
  output irpd_pkg::qentry_t               q_entry,
  output irpd_pkg::front_status_t         status
);
  import irpd_pkg::*;

  logic                  last_level;
  logic [TICK_W-1:0]     last_edge_tick;
  logic [CODE_W-1:0]     code_buf;
  logic [2:0]            bit_pos;
  logic [BYTE_POS_W-1:0] byte_pos;

  logic                  in_fire;
  cmd_t                  cmd;
  logic                  level;
  logic [TICK_W-1:0]     tick;
  logic [TICK_W-1:0]     interval;
  logic                  take_edge;
  logic                  one_bit;
  logic                  in_match_range;
  logic [CODE_IDX_W-1:0] bit_idx;
  match_t                kind;

  // unpack the input word
  assign cmd     = cmd_t'(s_axis_tuser);
  assign level   = s_axis_tdata[0];
  assign tick    = s_axis_tdata[TICK_W:1];

  assign s_axis_tready = !q_full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // edge qualification and bit value
  assign interval       = tick - last_edge_tick;
  assign one_bit        = interval > {{(TICK_W-THR_W){1'b0}}, cfg.bit_threshold};
  assign take_edge      = (level != last_level) && (byte_pos < BYTE_POS_W'(BUFFER_BYTES));
  assign in_match_range = byte_pos < BYTE_POS_W'(MATCH_BYTES);
  assign bit_idx        = {byte_pos[MATCH_IDX_W-1:0], bit_pos};

  // pattern compare, in priority order
  always_comb begin
    if (code_buf[POWER_BYTES*8-1:0] == PAT_POWER_ON) begin
      kind = MATCH_POWER_ON;
    end else if (code_buf[POWER_BYTES*8-1:0] == PAT_POWER_OFF) begin
      kind = MATCH_POWER_OFF;
    end else if (code_buf == PAT_VOL_UP) begin
      kind = MATCH_VOL_UP;
    end else if (code_buf == PAT_VOL_DOWN) begin
      kind = MATCH_VOL_DOWN;
    end else begin
      kind = MATCH_NONE;
    end
  end

  assign q_push        = in_fire && (cmd == CMD_TIMEOUT);
  assign q_entry.kind  = kind;
  assign q_entry.tick  = tick;

  assign status.byte_pos = byte_pos;
  assign status.bit_pos  = bit_pos;

  // code collection state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level     <= 1'b1;
      last_edge_tick <= '0;
      code_buf       <= '0;
      bit_pos        <= '0;
      byte_pos       <= '0;
    end else if (in_fire) begin
      unique case (cmd)
        CMD_EDGE: begin
          if (take_edge) begin
            last_level     <= level;
            last_edge_tick <= tick;
            if (one_bit && in_match_range) begin
              code_buf[bit_idx] <= 1'b1;
            end
            if (bit_pos == 3'd7) begin
              byte_pos <= byte_pos + 1'b1;
            end
            bit_pos <= bit_pos + 1'b1;
          end
        end
        CMD_TIMEOUT: begin
          if (!cfg.learn_mode) begin
            code_buf <= '0;
            bit_pos  <= '0;
            byte_pos <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/irpd_queue.sv @@
// ----------------------------------------------------------------------------
// irpd_queue
// Short first-in first-out queue of classified bursts between front and back.
// ----------------------------------------------------------------------------
module irpd_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  irpd_pkg::qentry_t             push_entry,
  output logic                          full,
  input  logic                          pop,
  output logic                          valid,
  output irpd_pkg::qentry_t             head,
  output logic [irpd_pkg::QCOUNT_W-1:0] count
);
  import irpd_pkg::*;

  qentry_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic                do_push;
  logic                do_pop;

  assign full    = count == QCOUNT_W'(QUEUE_DEPTH);
  assign valid   = count != '0;
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/irpd_back.sv @@
// ----------------------------------------------------------------------------
// irpd_back
// Turns a classified burst into an action word, with volume repeat timing.
// ----------------------------------------------------------------------------
module irpd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  irpd_pkg::cfg_t                 cfg,
  input  logic                           q_valid,
  input  irpd_pkg::qentry_t              q_head,
  output logic                           q_pop,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [irpd_pkg::M_TDATA_W-1:0] m_axis_tdata  // action, volume_step, zero pad
);
  import irpd_pkg::*;

  logic [TICK_W-1:0]        last_volume_tick;
  action_t                  action;
  logic signed [STEP_W-1:0] volume_step;

  logic [TICK_W-1:0] elapsed;
  logic              in_window;
  logic [STEP_W-1:0] mag;
  action_t           action_next;
  logic [STEP_W-1:0] step_next;
  logic              is_volume;

  // output register is free or being emptied this cycle
  assign q_pop = q_valid && (!m_axis_tvalid || m_axis_tready);

  // repeat timing
  assign elapsed   = q_head.tick - last_volume_tick;
  assign in_window = elapsed < {{(TICK_W-WINDOW_W){1'b0}}, cfg.repeat_window};
  assign mag       = in_window ? STEP_REPEAT : STEP_SINGLE;

  // action decode
  always_comb begin
    unique case (q_head.kind)
      MATCH_POWER_ON: begin
        action_next = ACT_POWER_ON;
        step_next   = '0;
      end
      MATCH_POWER_OFF: begin
        action_next = ACT_POWER_OFF;
        step_next   = '0;
      end
      MATCH_VOL_UP: begin
        action_next = ACT_VOLUME;
        step_next   = mag;
      end
      MATCH_VOL_DOWN: begin
        action_next = ACT_VOLUME;
        step_next   = '0 - mag;
      end
      default: begin
        action_next = ACT_NONE;
        step_next   = '0;
      end
    endcase
  end

  assign is_volume = (q_head.kind == MATCH_VOL_UP) || (q_head.kind == MATCH_VOL_DOWN);

  // output word register and volume timestamp
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid    <= 1'b0;
      last_volume_tick <= '0;
    end else begin
      if (q_pop) begin
        m_axis_tvalid <= 1'b1;
        if (is_volume) begin
          last_volume_tick <= q_head.tick;
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      action      <= action_next;
      volume_step <= step_next;
    end
  end

  assign m_axis_tdata = {{(M_TDATA_W-ACTION_W-STEP_W){1'b0}}, volume_step, action};

endmodule

@@ hdl/ir_pulse_distance_command_decoder_core.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_distance_command_decoder_core
// IR remote pulse-distance decoder: collects edge bits, matches key codes.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle on the input, edges and timeouts alike.
// A timeout's result word passes through the front-to-back queue and then
//   the output register.
// Input stalls only when the two-entry queue is full behind a stalled output.
// Reset: synchronous; registers take their defaults, code buffer cleared,
//   queue and output empty.
module ir_pulse_distance_command_decoder_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [irpd_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // level, tick, zero pad
  input  logic                            s_axis_tuser,  // cmd
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [irpd_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // action, volume_step, zero pad
  input  logic                            cfg_we,
  input  logic [irpd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [irpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import irpd_pkg::*;

  cfg_t              cfg;
  logic              q_push;
  qentry_t           q_entry;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  qentry_t           q_head;
  logic [QCOUNT_W-1:0] q_count;
  front_status_t     fstat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_threshold <= THR_RESET;
      cfg.repeat_window <= WINDOW_RESET;
      cfg.learn_mode    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_BIT_THRESHOLD: cfg.bit_threshold <= cfg_wdata[THR_W-1:0];
        CFG_REPEAT_WINDOW: cfg.repeat_window <= cfg_wdata[WINDOW_W-1:0];
        CFG_LEARN_MODE:    cfg.learn_mode    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  irpd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg           (cfg),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry),
    .status        (fstat)
  );

  irpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head),
    .count      (q_count)
  );

  irpd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // timeout without learn mode leaves an empty code
  a_clear_on_timeout: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser && !cfg.learn_mode)
      |=> (fstat.byte_pos == '0) && (fstat.bit_pos == '0))
    else $error("code buffer not cleared after timeout");

  // fill position never runs past the buffer, and a full buffer sits on a byte boundary
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (fstat.byte_pos <= BYTE_POS_W'(BUFFER_BYTES))
      && ((fstat.byte_pos != BYTE_POS_W'(BUFFER_BYTES)) || (fstat.bit_pos == '0)))
    else $error("code fill position out of range");

  // a volume step goes with the volume action and only with it
  a_step_action: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[ACTION_W-1:0] == ACT_VOLUME)
                       == (m_axis_tdata[ACTION_W+STEP_W-1:ACTION_W] != '0)))
    else $error("volume step inconsistent with action");

  // queue fill count bounded by its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCOUNT_W'(QUEUE_DEPTH))
    else $error("queue overfilled");

endmodule
